>>> hw/rtl/oqrp_pkg.sv
// Shared types and constants for the owner quota residency policy block.
package oqrp_pkg;

    // Default sizes handed to the top level parameters.
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int OWNER_BITS_DEF    = 22;

    // Quota percent registers and the percent scale.
    localparam int PCT_BITS = 7;
    localparam logic [PCT_BITS-1:0] PCT_SCALE = PCT_BITS'(100);

    localparam int KIND_BITS    = 2;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ACTIVATE = 2'd0,
        KIND_USED     = 2'd1,
        KIND_EVICT    = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PRIO_OWNER   = 3'd0,
        CFG_PRIO_PCT     = 3'd1,
        CFG_LOW_OWNER    = 3'd2,
        CFG_LOW_PCT      = 3'd3,
        CFG_DEFAULT_PCT  = 3'd4
    } cfg_idx_t;

endpackage

>>> hw/rtl/oqrp_table.sv
// Owner table memory: tag and active count per entry, one write and one registered read port.
module oqrp_table #(
    parameter int ENTRIES    = oqrp_pkg::TABLE_ENTRIES_DEF,
    parameter int TAG_BITS   = oqrp_pkg::OWNER_BITS_DEF,
    parameter int COUNT_BITS = oqrp_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic [TAG_BITS-1:0]        rd_tag,
    output logic [COUNT_BITS-1:0]      rd_count,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  logic [TAG_BITS-1:0]        wr_tag,
    input  logic [COUNT_BITS-1:0]      wr_count
);
    import oqrp_pkg::*;

    logic [TAG_BITS-1:0]   tag_mem   [ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr]   <= wr_tag;
            count_mem[wr_addr] <= wr_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tag   <= tag_mem[rd_addr];
            rd_count <= count_mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/oqrp_mac.sv
// Shift-add multiplier that takes one multiplier bit per cycle.
module oqrp_mac #(
    parameter int MCAND_BITS = oqrp_pkg::COUNT_BITS_DEF + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [MCAND_BITS-1:0]                   mcand,
    input  logic [oqrp_pkg::PCT_BITS-1:0]           mplier,
    output logic                                    done,
    output logic [MCAND_BITS+oqrp_pkg::PCT_BITS-1:0] product
);
    import oqrp_pkg::*;

    localparam int PROD_BITS = MCAND_BITS + PCT_BITS;
    localparam int STEP_BITS = $clog2(PCT_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(PCT_BITS - 1);

    logic                 run_reg,    run_next;
    logic                 done_reg,   done_next;
    logic [STEP_BITS-1:0] step_reg,   step_next;
    logic [PROD_BITS-1:0] acc_reg,    acc_next;
    logic [PROD_BITS-1:0] shift_reg,  shift_next;
    logic [PCT_BITS-1:0]  mplier_reg, mplier_next;

    always_comb
    begin
        run_next    = run_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            run_next    = 1'b1;
            step_next   = '0;
            acc_next    = '0;
            shift_next  = PROD_BITS'(mcand);
            mplier_next = mplier;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + shift_reg;
            shift_next  = shift_reg << 1;
            mplier_next = mplier_reg >> 1;
            step_next   = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        shift_reg  <= shift_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> hw/rtl/owner_quota_residency_policy_unit.sv
// Owner quota residency policy: owner count table, event sequencer and quota check.
//
// Each event transaction is handled alone. The sequencer scans the owner table
// through its single read port, one entry per cycle, over the N owners held so
// far (at most TABLE_ENTRIES). A used event with a nonzero percent adds two
// passes through the shared shift-add multiplier; each pass steps through the
// seven multiplier bits and then raises done. Events with owner 0 or an unused
// kind skip the scan. A stalled result holds the event in the finish state
// until the output register is free. Entries are filled in order and never
// freed, so a fill count stands in for valid bits and no clearing pass is
// needed after reset. A finished result waits in an output register while the
// next event is accepted.
module owner_quota_residency_policy_unit #(
    parameter int TABLE_ENTRIES = oqrp_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = oqrp_pkg::COUNT_BITS_DEF,
    parameter int OWNER_BITS    = oqrp_pkg::OWNER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [oqrp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [OWNER_BITS-1:0]             cfg_data,
    input  logic                              evt_valid,
    output logic                              evt_stall,
    input  logic [oqrp_pkg::KIND_BITS-1:0]    kind,
    input  logic [OWNER_BITS-1:0]             owner_id,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              policy_handled,
    output logic                              move_to_tail,
    output logic                              insert_dropped
);
    import oqrp_pkg::*;

    localparam int AW        = $clog2(TABLE_ENTRIES);
    localparam int FW        = AW + 1;
    localparam bit SUM_SAT   = (COUNT_BITS + 1 > 64);
    localparam int TOT_BITS  = SUM_SAT ? 64 : COUNT_BITS + 1;
    localparam int PROD_BITS = TOT_BITS + PCT_BITS;
    localparam logic [FW-1:0] FULL = FW'(TABLE_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_MUL_A  = 5'b00100,
        ST_MUL_B  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // Configuration registers.
    logic [OWNER_BITS-1:0] prio_owner_reg;
    logic [PCT_BITS-1:0]   prio_pct_reg;
    logic [OWNER_BITS-1:0] low_owner_reg;
    logic [PCT_BITS-1:0]   low_pct_reg;
    logic [PCT_BITS-1:0]   dflt_pct_reg;

    state_t                state_reg,    state_next;
    logic [KIND_BITS-1:0]  kind_reg,     kind_next;
    logic [OWNER_BITS-1:0] owner_reg,    owner_next;
    logic [FW-1:0]         fill_reg,     fill_next;
    logic [FW-1:0]         scan_reg,     scan_next;
    logic                  rd_pend_reg,  rd_pend_next;
    logic [AW-1:0]         rd_idx_reg,   rd_idx_next;
    logic                  hit_reg,      hit_next;
    logic [AW-1:0]         hit_idx_reg,  hit_idx_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg,  hit_cnt_next;
    logic [COUNT_BITS-1:0] p_cnt_reg,    p_cnt_next;
    logic [COUNT_BITS-1:0] l_cnt_reg,    l_cnt_next;
    logic [PCT_BITS-1:0]   pct_reg,      pct_next;
    logic [PROD_BITS-1:0]  prod_a_reg,   prod_a_next;
    logic                  w_hand_reg,   w_hand_next;
    logic                  w_move_reg,   w_move_next;
    logic                  w_drop_reg,   w_drop_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  res_hand_reg, res_hand_next;
    logic                  res_move_reg, res_move_next;
    logic                  res_drop_reg, res_drop_next;

    // Table and multiplier hookup.
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [OWNER_BITS-1:0] rd_tag;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [OWNER_BITS-1:0] wr_tag;
    logic [COUNT_BITS-1:0] wr_count;
    logic                  mac_start;
    logic [TOT_BITS-1:0]   mac_mcand;
    logic [PCT_BITS-1:0]   mac_mplier;
    logic                  mac_done;
    logic [PROD_BITS-1:0]  mac_product;

    logic                  evt_accept;
    logic                  issue;
    logic [COUNT_BITS:0]   sum_full;
    logic [TOT_BITS-1:0]   total_sat;
    logic [TOT_BITS-1:0]   total;
    logic [PCT_BITS-1:0]   pct_sel;
    logic                  out_free;

    oqrp_table #(
        .ENTRIES    (TABLE_ENTRIES),
        .TAG_BITS   (OWNER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_tag   (rd_tag),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_tag   (wr_tag),
        .wr_count (wr_count)
    );

    oqrp_mac #(
        .MCAND_BITS (TOT_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mac_start),
        .mcand   (mac_mcand),
        .mplier  (mac_mplier),
        .done    (mac_done),
        .product (mac_product)
    );

    assign cfg_ready  = 1'b1;
    assign evt_stall  = (state_reg != ST_IDLE);
    assign evt_accept = evt_valid && !evt_stall;
    assign issue      = (scan_reg < fill_reg);
    assign out_free   = !res_valid_reg || !res_stall;

    // Sum of the two named owners' counts, saturated, at least 1.
    always_comb
    begin
        sum_full = {1'b0, (prio_owner_reg != '0) ? p_cnt_reg : COUNT_BITS'(0)}
                 + {1'b0, (low_owner_reg != '0) ? l_cnt_reg : COUNT_BITS'(0)};
        if (SUM_SAT && sum_full[COUNT_BITS])
            total_sat = '1;
        else
            total_sat = sum_full[TOT_BITS-1:0];
        total = (total_sat == '0) ? TOT_BITS'(1) : total_sat;
    end

    always_comb
    begin
        if (prio_owner_reg != '0 && owner_reg == prio_owner_reg)
            pct_sel = prio_pct_reg;
        else if (low_owner_reg != '0 && owner_reg == low_owner_reg)
            pct_sel = low_pct_reg;
        else
            pct_sel = dflt_pct_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        owner_next     = owner_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = scan_reg[AW-1:0];
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        p_cnt_next     = p_cnt_reg;
        l_cnt_next     = l_cnt_reg;
        pct_next       = pct_reg;
        prod_a_next    = prod_a_reg;
        w_hand_next    = w_hand_reg;
        w_move_next    = w_move_reg;
        w_drop_next    = w_drop_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_hand_next  = res_hand_reg;
        res_move_next  = res_move_reg;
        res_drop_next  = res_drop_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = hit_idx_reg;
        wr_tag         = owner_reg;
        wr_count       = hit_cnt_reg;
        mac_start      = 1'b0;
        mac_mcand      = total;
        mac_mplier     = pct_sel;

        case (state_reg)
            ST_IDLE:
            begin
                if (evt_accept)
                begin
                    kind_next    = kind;
                    owner_next   = owner_id;
                    scan_next    = '0;
                    hit_next     = 1'b0;
                    hit_cnt_next = '0;
                    p_cnt_next   = '0;
                    l_cnt_next   = '0;
                    w_hand_next  = 1'b0;
                    w_move_next  = 1'b0;
                    w_drop_next  = 1'b0;
                    if (owner_id == '0 || kind_t'(kind) != KIND_ACTIVATE
                        && kind_t'(kind) != KIND_USED && kind_t'(kind) != KIND_EVICT)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Reads are pipelined: an entry is compared the cycle after its read.
                if (issue)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    scan_next    = scan_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if (rd_tag == owner_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                        hit_cnt_next = rd_count;
                    end
                    if (rd_tag == prio_owner_reg)
                        p_cnt_next = rd_count;
                    if (rd_tag == low_owner_reg)
                        l_cnt_next = rd_count;
                end
                if (!issue && !rd_pend_reg)
                begin
                    state_next = ST_FINISH;
                    case (kind_reg)
                        KIND_ACTIVATE:
                        begin
                            if (hit_reg)
                            begin
                                wr_en = 1'b1;
                                if (hit_cnt_reg != '1)
                                    wr_count = hit_cnt_reg + 1'b1;
                            end
                            else if (fill_reg < FULL)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = fill_reg[AW-1:0];
                                wr_count  = COUNT_BITS'(1);
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                                w_drop_next = 1'b1;
                        end
                        KIND_EVICT:
                        begin
                            if (hit_reg && hit_cnt_reg != '0)
                            begin
                                wr_en    = 1'b1;
                                wr_count = hit_cnt_reg - 1'b1;
                            end
                        end
                        KIND_USED:
                        begin
                            pct_next = pct_sel;
                            if (pct_sel != '0)
                            begin
                                mac_start  = 1'b1;
                                state_next = ST_MUL_A;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_MUL_A:
            begin
                // Second pass forms 100 times the owner's count.
                mac_mcand  = TOT_BITS'(hit_cnt_reg);
                mac_mplier = PCT_SCALE;
                if (mac_done)
                begin
                    prod_a_next = mac_product;
                    mac_start   = 1'b1;
                    state_next  = ST_MUL_B;
                end
            end

            ST_MUL_B:
            begin
                // count <= max(floor(total * pct / 100), 1), without a divide.
                if (mac_done)
                begin
                    w_hand_next = 1'b1;
                    w_move_next = (hit_cnt_reg <= COUNT_BITS'(1))
                                  || (prod_a_reg >= mac_product);
                    state_next  = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_hand_next  = w_hand_reg;
                    res_move_next  = w_move_reg;
                    res_drop_next  = w_drop_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_owner_reg <= '0;
            prio_pct_reg   <= '0;
            low_owner_reg  <= '0;
            low_pct_reg    <= '0;
            dflt_pct_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PRIO_OWNER:  prio_owner_reg <= cfg_data;
                CFG_PRIO_PCT:    prio_pct_reg   <= cfg_data[PCT_BITS-1:0];
                CFG_LOW_OWNER:   low_owner_reg  <= cfg_data;
                CFG_LOW_PCT:     low_pct_reg    <= cfg_data[PCT_BITS-1:0];
                CFG_DEFAULT_PCT: dflt_pct_reg   <= cfg_data[PCT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_pend_reg   <= rd_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        owner_reg    <= owner_next;
        scan_reg     <= scan_next;
        rd_idx_reg   <= rd_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        p_cnt_reg    <= p_cnt_next;
        l_cnt_reg    <= l_cnt_next;
        pct_reg      <= pct_next;
        prod_a_reg   <= prod_a_next;
        w_hand_reg   <= w_hand_next;
        w_move_reg   <= w_move_next;
        w_drop_reg   <= w_drop_next;
        res_hand_reg <= res_hand_next;
        res_move_reg <= res_move_next;
        res_drop_reg <= res_drop_next;
    end

    assign res_valid      = res_valid_reg;
    assign policy_handled = res_hand_reg;
    assign move_to_tail   = res_move_reg;
    assign insert_dropped = res_drop_reg;

endmodule
